[rtl/core/amcf_pkg.sv]
// Shared constants, types and codes for the audio module command framer.
package amcf_pkg;

    // Width of the saturating millisecond counter.
    localparam int COUNTER_WIDTH = 16;
    // Compare width for counter against the 16-bit timeout register.
    localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

    localparam int FRAME_LEN = 10;
    localparam int POS_W     = 4;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Config register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY_LINE_USED = 1'd1;
    localparam logic [15:0] START_TIMEOUT_RST = 16'd1000;

    // Request types.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    // Frame bytes and play codes.
    localparam logic [7:0] FR_START    = 8'h7E;
    localparam logic [7:0] FR_VERSION  = 8'hFF;
    localparam logic [7:0] FR_LENGTH   = 8'h06;
    localparam logic [7:0] FR_FEEDBACK = 8'h01;
    localparam logic [7:0] FR_CK_HI    = 8'hFE;
    localparam logic [7:0] FR_END      = 8'hEF;
    localparam logic [7:0] CMD_PLAY_TRACK  = 8'h03;
    localparam logic [7:0] CMD_PLAY_FOLDER = 8'h0D;

    // One classified item in the queue.
    typedef struct packed {
        logic        is_cmd;
        logic [7:0]  code;
        logic [15:0] param;
        logic [7:0]  ck;
        logic        busy;
        logic        tout;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[rtl/core/amcf_front.sv]
// Front end: config registers, play tracker, checksum and item classification.
module amcf_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [7:0]                            s_command_code,
    input  logic [15:0]                           s_parameter_req,
    input  logic                                  s_busy_pin_level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [amcf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [15:0]                           cfg_data,
    input  amcf_pkg::q_status_t                   q_status,
    output amcf_pkg::push_t                       push
);

    logic [15:0] timeout_reg;
    logic        busy_used_reg;
    logic        pending_reg, pending_next;
    logic        seen_reg, seen_next;
    logic [amcf_pkg::COUNTER_WIDTH-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic        accept;
    logic        playing;
    logic        is_play;
    logic        tout;
    logic [7:0]  sum;

    assign s_ready   = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign playing   = !s_busy_pin_level;
    assign is_play   = (s_command_code == amcf_pkg::CMD_PLAY_TRACK) ||
                       (s_command_code == amcf_pkg::CMD_PLAY_FOLDER);
    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;

    always_comb begin
        pending_next = pending_reg;
        seen_next    = seen_reg;
        elapsed_next = elapsed_reg;
        tout         = 1'b0;
        if (s_req_type == amcf_pkg::REQ_CMD) begin
            if (is_play) begin
                pending_next = 1'b1;
                seen_next    = 1'b0;
                elapsed_next = '0;
            end
        end else begin
            elapsed_next = elapsed_inc;
            if (busy_used_reg) begin
                if (!seen_reg && playing && pending_reg) begin
                    seen_next    = 1'b1;
                    elapsed_next = '0;
                end else if (seen_reg && !playing && pending_reg) begin
                    seen_next    = 1'b0;
                    pending_next = 1'b0;
                end else if (!seen_reg && !playing && pending_reg &&
                             (amcf_pkg::CMP_W'(elapsed_inc) >
                              amcf_pkg::CMP_W'(timeout_reg))) begin
                    pending_next = 1'b0;
                    tout         = 1'b1;
                end
            end
        end
    end

    // Bytes 2..7 summed; inverted below.
    assign sum = amcf_pkg::FR_LENGTH + s_command_code + amcf_pkg::FR_FEEDBACK +
                 s_parameter_req[15:8] + s_parameter_req[7:0] + amcf_pkg::FR_CK_HI;

    always_comb begin
        push.valid        = accept;
        push.entry.is_cmd = (s_req_type == amcf_pkg::REQ_CMD);
        push.entry.code   = s_command_code;
        push.entry.param  = s_parameter_req;
        push.entry.ck     = ~sum;
        push.entry.busy   = busy_used_reg && (seen_next || pending_next);
        push.entry.tout   = tout;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= amcf_pkg::START_TIMEOUT_RST;
            busy_used_reg <= 1'b1;
            pending_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            elapsed_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    amcf_pkg::REG_START_TIMEOUT:  timeout_reg   <= cfg_data;
                    amcf_pkg::REG_BUSY_LINE_USED: busy_used_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                pending_reg <= pending_next;
                seen_reg    <= seen_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

endmodule

[rtl/core/amcf_queue.sv]
// Small FIFO of classified items between front and back.
module amcf_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  amcf_pkg::push_t      push,
    input  logic                 pop,
    output amcf_pkg::entry_t     head,
    output amcf_pkg::q_status_t  q_status
);

    amcf_pkg::entry_t mem [amcf_pkg::Q_DEPTH];
    logic [amcf_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [amcf_pkg::Q_CNT_W-1:0] count_reg, count_next;

    assign head           = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == amcf_pkg::Q_CNT_W'(amcf_pkg::Q_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/amcf_back.sv]
// Back end: serializes frames and status results into the output register.
module amcf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  amcf_pkg::entry_t     head,
    input  amcf_pkg::q_status_t  q_status,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_byte_valid,
    output logic                 m_last_of_run,
    output logic                 m_player_busy,
    output logic                 m_start_timed_out
);

    logic [amcf_pkg::POS_W-1:0] pos_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg, last_reg, busy_reg, tout_reg;
    logic       advance, take, at_last;
    logic [7:0] frame_byte;

    assign advance = !valid_reg || m_ready;
    assign take    = advance && !q_status.empty;
    assign at_last = (pos_reg == amcf_pkg::LAST_POS);
    assign pop     = take && (!head.is_cmd || at_last);

    always_comb begin
        case (pos_reg)
            4'd0:    frame_byte = amcf_pkg::FR_START;
            4'd1:    frame_byte = amcf_pkg::FR_VERSION;
            4'd2:    frame_byte = amcf_pkg::FR_LENGTH;
            4'd3:    frame_byte = head.code;
            4'd4:    frame_byte = amcf_pkg::FR_FEEDBACK;
            4'd5:    frame_byte = head.param[15:8];
            4'd6:    frame_byte = head.param[7:0];
            4'd7:    frame_byte = amcf_pkg::FR_CK_HI;
            4'd8:    frame_byte = head.ck;
            default: frame_byte = amcf_pkg::FR_END;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg   <= head.is_cmd ? frame_byte : 8'h00;
            bvalid_reg <= head.is_cmd;
            last_reg   <= !head.is_cmd || at_last;
            busy_reg   <= head.busy;
            tout_reg   <= head.is_cmd ? 1'b0 : head.tout;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            if (advance) begin
                valid_reg <= !q_status.empty;
            end
            if (take && head.is_cmd) begin
                pos_reg <= at_last ? '0 : pos_reg + 1'b1;
            end
        end
    end

    assign m_valid           = valid_reg;
    assign m_out_byte        = byte_reg;
    assign m_byte_valid      = bvalid_reg;
    assign m_last_of_run     = last_reg;
    assign m_player_busy     = busy_reg;
    assign m_start_timed_out = tout_reg;

endmodule

[rtl/core/audio_module_command_framer_unit.sv]
// Top level of the audio module command framer: front, queue and back end.
// Each accepted item is written into the queue, then its results leave through the output register.
// A command goes out as 10 frame bytes, one byte per cycle while m_ready holds, a tick as one status result;
// the output register and serializer set that pace, input takes one item/cycle while
// the 4-entry queue has room.
// Reset (aresetn low, synchronous): tracker, queue and output clear; timeout=1000, busy line used.
module audio_module_command_framer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input item channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [7:0]                       s_command_code,
    input  logic [15:0]                      s_parameter_req,
    input  logic                             s_busy_pin_level,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_byte_valid,
    output logic                             m_last_of_run,
    output logic                             m_player_busy,
    output logic                             m_start_timed_out,
    // Config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [amcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                      cfg_data
);

    amcf_pkg::push_t     push;
    amcf_pkg::q_status_t q_status;
    amcf_pkg::entry_t    head;
    logic                pop;

    // Front: tracker state updates and checksum are settled at transfer time,
    // so each queued item already carries its status bits.
    amcf_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_command_code   (s_command_code),
        .s_parameter_req  (s_parameter_req),
        .s_busy_pin_level (s_busy_pin_level),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .q_status         (q_status),
        .push             (push)
    );

    // Decouples intake from the frame serialization.
    amcf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    // Back: walks the frame byte index and drives the output register.
    amcf_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head              (head),
        .q_status          (q_status),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_byte_valid      (m_byte_valid),
        .m_last_of_run     (m_last_of_run),
        .m_player_busy     (m_player_busy),
        .m_start_timed_out (m_start_timed_out)
    );

`ifndef ASSERT_OFF
    // Status results are single, zero-byte and end their run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_last_of_run && (m_out_byte == 8'h00))
        else $error("status result malformed");

    // Timeout flag only appears on status results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_timed_out |-> !m_byte_valid)
        else $error("timeout flag on frame byte");

    // Final frame byte is always the end marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid && m_last_of_run |-> m_out_byte == amcf_pkg::FR_END)
        else $error("frame does not end with end marker");

    // A frame byte right after a finished run is the start marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_run ##1 m_valid && m_byte_valid
        |-> (m_out_byte == amcf_pkg::FR_START))
        else $error("frame does not begin with start marker");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for the audio module command framer: frame bytes and tick status.
`timescale 1ns / 100ps

module tb;

    localparam int  HALF_PERIOD  = 6;
    localparam int  RESET_CYCLES = 6;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  CYCLE_LIMIT  = 200_000;
    localparam int  RAND_ITEMS   = 148;
    localparam int  MAX_REPORTS  = 10;
    // Stop command; framed as given, tracking untouched.
    localparam logic [7:0] CMD_STOP = 8'h16;

    // One input item as it goes out on the s_ channel.
    typedef struct packed {
        logic        req;
        logic [7:0]  code;
        logic [15:0] param;
        logic        level;
    } req_item_t;

    // One result as it should appear on the m_ channel.
    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       last;
        logic       busy;
        logic       tout;
    } out_word_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs at known values from time zero
    // ------------------------------------------------------------------
    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic                 s_req_type        = amcf_pkg::REQ_TICK;
    logic [7:0]           s_command_code    = 8'h00;
    logic [15:0]          s_parameter_req   = 16'h0000;
    logic                 s_busy_pin_level  = 1'b1;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [7:0]           m_out_byte;
    logic                 m_byte_valid;
    logic                 m_last_of_run;
    logic                 m_player_busy;
    logic                 m_start_timed_out;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [amcf_pkg::CFG_IDX_W-1:0] cfg_index = amcf_pkg::REG_START_TIMEOUT;
    logic [15:0]          cfg_data          = 16'h0000;

    audio_module_command_framer_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_command_code    (s_command_code),
        .s_parameter_req   (s_parameter_req),
        .s_busy_pin_level  (s_busy_pin_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_byte_valid      (m_byte_valid),
        .m_last_of_run     (m_last_of_run),
        .m_player_busy     (m_player_busy),
        .m_start_timed_out (m_start_timed_out),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    req_item_t pending_items[$];   // filled by the sequencer, drained by the driver
    out_word_t expected_out[$];    // predicted results, oldest first

    // Shadow of the configuration registers (updated on each cfg transfer).
    logic [15:0] shadow_timeout = amcf_pkg::START_TIMEOUT_RST;
    logic        shadow_used    = 1'b1;

    // Shadow of the play tracker.
    logic                               trk_pending = 1'b0;
    logic                               trk_busy    = 1'b0;
    logic [amcf_pkg::COUNTER_WIDTH-1:0] trk_ms      = '0;

    // Idling on both sides can be switched off for a back-to-back stretch.
    logic idle_en = 1'b1;

    int errors       = 0;
    int checked      = 0;
    int n_frames     = 0;
    int n_ticks      = 0;
    int n_timeouts   = 0;
    int n_settings   = 1;
    int queued_items = 0;
    int cycles       = 0;

    // ------------------------------------------------------------------
    // Predictor: one accepted item -> its results, in order
    // ------------------------------------------------------------------
    task automatic predict_frame_or_status(input req_item_t it);
        logic [7:0] fr[amcf_pkg::FRAME_LEN];
        logic [7:0] sum;
        logic       playing;
        logic       tout;
        out_word_t  w;
        if (it.req == amcf_pkg::REQ_CMD) begin
            fr[0] = amcf_pkg::FR_START;
            fr[1] = amcf_pkg::FR_VERSION;
            fr[2] = amcf_pkg::FR_LENGTH;
            fr[3] = it.code;
            fr[4] = amcf_pkg::FR_FEEDBACK;
            fr[5] = it.param[15:8];
            fr[6] = it.param[7:0];
            fr[7] = amcf_pkg::FR_CK_HI;
            fr[9] = amcf_pkg::FR_END;
            sum = 8'h00;
            for (int i = 2; i < 8; i++) sum = sum + fr[i];
            fr[8] = ~sum;
            // Play codes re-arm the tracker before the status bit is taken.
            if (it.code == amcf_pkg::CMD_PLAY_TRACK ||
                it.code == amcf_pkg::CMD_PLAY_FOLDER) begin
                trk_pending = 1'b1;
                trk_busy    = 1'b0;
                trk_ms      = '0;
            end
            for (int i = 0; i < amcf_pkg::FRAME_LEN; i++) begin
                w.data   = fr[i];
                w.bvalid = 1'b1;
                w.last   = (i == amcf_pkg::FRAME_LEN - 1);
                w.busy   = shadow_used & (trk_busy | trk_pending);
                w.tout   = 1'b0;
                expected_out.push_back(w);
            end
            n_frames++;
        end else begin
            playing = (it.level == 1'b0);
            tout    = 1'b0;
            // Wall-clock counter runs regardless of the busy line setting.
            if (trk_ms != '1) trk_ms = trk_ms + 1'b1;
            if (shadow_used) begin
                if (!trk_busy && playing && trk_pending) begin
                    trk_busy = 1'b1;
                    trk_ms   = '0;
                end else if (trk_busy && !playing && trk_pending) begin
                    trk_busy    = 1'b0;
                    trk_pending = 1'b0;
                end else if (!trk_busy && !playing && trk_pending &&
                             trk_ms > shadow_timeout) begin
                    trk_pending = 1'b0;
                    tout        = 1'b1;
                end
            end
            w.data   = 8'h00;
            w.bvalid = 1'b0;
            w.last   = 1'b1;
            w.busy   = shadow_used & (trk_busy | trk_pending);
            w.tout   = tout;
            expected_out.push_back(w);
            n_ticks++;
            if (tout) n_timeouts++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    req_item_t next_item;
    int        gap_left   = 0;
    int        burst_left = 1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // Transfer happened on this edge: predict from what was on the bus.
            if (s_valid && s_ready)
                predict_frame_or_status({s_req_type, s_command_code,
                                         s_parameter_req, s_busy_pin_level});
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    s_valid          <= 1'b1;
                    s_req_type       <= next_item.req;
                    s_command_code   <= next_item.code;
                    s_parameter_req  <= next_item.param;
                    s_busy_pin_level <= next_item.level;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        // About a quarter of bursts run straight into the next one.
                        if (!idle_en || $urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: receiver stalls on an 8-bit mask indexed by pat_cnt[2:0], redrawn
    // when pat_cnt[5:0] wraps; bit 0 of the mask is never a stall so the channel can't lock.
    // ------------------------------------------------------------------
    logic [7:0]  stall_mask = 8'h00;
    logic [31:0] pat_cnt    = '0;

    task automatic check_result();
        out_word_t want;
        if (expected_out.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] result with nothing expected: ", $realtime,
                         "byte=%h bv=%b last=%b busy=%b to=%b",
                         m_out_byte, m_byte_valid, m_last_of_run,
                         m_player_busy, m_start_timed_out);
        end else begin
            want = expected_out.pop_front();
            checked++;
            if (m_out_byte !== want.data || m_byte_valid !== want.bvalid ||
                m_last_of_run !== want.last || m_player_busy !== want.busy ||
                m_start_timed_out !== want.tout) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] mismatch ", $realtime,
                             "exp byte=%h bv=%b last=%b busy=%b to=%b | ",
                             want.data, want.bvalid, want.last, want.busy, want.tout,
                             "got byte=%h bv=%b last=%b busy=%b to=%b",
                             m_out_byte, m_byte_valid, m_last_of_run,
                             m_player_busy, m_start_timed_out);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result();
            pat_cnt = pat_cnt + 1;
            if (pat_cnt[5:0] == 6'd0) begin
                if (idle_en && $urandom_range(0, 3) != 0)
                    stall_mask = 8'($urandom) & 8'hFE;
                else
                    stall_mask = 8'h00;
            end
            m_ready <= !stall_mask[pat_cnt[2:0]];
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_out.size());
            $display("FAIL audio_module_command_framer_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [7:0] code, input logic [15:0] param);
        pending_items.push_back({amcf_pkg::REQ_CMD, code, param, 1'($urandom)});
        queued_items++;
    endtask

    task automatic push_tick(input logic level);
        pending_items.push_back({amcf_pkg::REQ_TICK, 8'($urandom), 16'($urandom), level});
        queued_items++;
    endtask

    // Wait until every queued item went out and every result came back,
    // then let the pipeline drain before touching config.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_out.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [amcf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == amcf_pkg::REG_START_TIMEOUT)
            shadow_timeout = val;
        else
            shadow_used = val[0];
        n_settings++;
    endtask

    // A play followed by a tick stream: busy may rise after some delay,
    // stays low a while, then releases. A few levels are flipped as noise.
    task automatic play_story();
        int rise_at;
        int dur;
        int total;
        logic lvl;
        push_cmd(($urandom_range(0, 1) != 0) ? amcf_pkg::CMD_PLAY_TRACK
                                             : amcf_pkg::CMD_PLAY_FOLDER,
                 16'($urandom));
        rise_at = $urandom_range(0, int'(shadow_timeout) + 3);
        dur     = $urandom_range(1, 6);
        total   = $urandom_range(0, rise_at + dur + 3);   // short totals break the story
        for (int t = 0; t < total; t++) begin
            lvl = (t >= rise_at && t < rise_at + dur) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 99) < 8) lvl = ~lvl;
            push_tick(lvl);
            if ($urandom_range(0, 99) < 5)
                push_cmd(CMD_STOP, 16'($urandom));
        end
    endtask

    task automatic noise_item();
        if ($urandom_range(0, 1) != 0)
            push_cmd(8'($urandom), 16'($urandom));
        else
            push_tick(1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int target;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: timeout 1000, busy line wired.
        push_cmd(8'h00, 16'h0000);            // all-zero fields
        push_cmd(8'hFF, 16'hFFFF);            // all-one fields
        push_cmd(CMD_STOP, 16'h0000);         // stop is an ordinary frame
        push_tick(1'b1);                      // tick with nothing pending
        push_tick(1'b0);                      // busy low but no play armed
        push_cmd(amcf_pkg::CMD_PLAY_TRACK, 16'h0001);
        push_tick(1'b1);                      // pending, well inside timeout
        push_tick(1'b0);                      // busy rises
        push_tick(1'b0);                      // still playing
        push_cmd(CMD_STOP, 16'h0000);         // non-play code leaves tracker alone
        push_tick(1'b1);                      // busy released: done
        push_cmd(amcf_pkg::CMD_PLAY_FOLDER, 16'hABCD);
        push_cmd(amcf_pkg::CMD_PLAY_TRACK, 16'h5A5A);   // re-arm while pending
        // Default timeout: a few idle ticks stay well inside it.
        for (int i = 0; i < 4; i++) push_tick(1'b1);
        wait_idle();

        // Zero timeout: first idle tick abandons the play.
        write_reg(amcf_pkg::REG_START_TIMEOUT, 16'd0);
        write_reg(amcf_pkg::REG_BUSY_LINE_USED, 16'd1);
        push_cmd(amcf_pkg::CMD_PLAY_TRACK, 16'h1234);
        push_tick(1'b1);
        push_cmd(amcf_pkg::CMD_PLAY_FOLDER, 16'h8000);
        push_tick(1'b0);
        push_tick(1'b1);
        wait_idle();

        // Busy line unused (only bit 0 of the data counts): ticks are inert.
        write_reg(amcf_pkg::REG_BUSY_LINE_USED, 16'h0002);
        push_cmd(amcf_pkg::CMD_PLAY_TRACK, 16'h00FF);
        push_tick(1'b0);
        push_tick(1'b1);
        wait_idle();
        // Back on: the play armed above is still pending and now times out.
        write_reg(amcf_pkg::REG_BUSY_LINE_USED, 16'd1);
        push_tick(1'b1);
        wait_idle();

        // Max timeout: a pending play is never abandoned. No idling here.
        idle_en = 1'b0;
        write_reg(amcf_pkg::REG_START_TIMEOUT, 16'hFFFF);
        push_cmd(amcf_pkg::CMD_PLAY_FOLDER, 16'hFF00);
        for (int i = 0; i < 8; i++) push_tick(1'b1);
        wait_idle();
        idle_en = 1'b1;

        // Random part, four settings; mostly play stories, some noise.
        queued_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(amcf_pkg::REG_START_TIMEOUT, 16'($urandom_range(0, 6)));
                    write_reg(amcf_pkg::REG_BUSY_LINE_USED, 16'd1);
                end
                1: begin
                    write_reg(amcf_pkg::REG_START_TIMEOUT, 16'd2);
                    write_reg(amcf_pkg::REG_BUSY_LINE_USED, 16'd0);
                end
                2: begin
                    write_reg(amcf_pkg::REG_START_TIMEOUT, 16'($urandom_range(3, 9)));
                    write_reg(amcf_pkg::REG_BUSY_LINE_USED, 16'd1);
                end
                default: begin
                    write_reg(amcf_pkg::REG_START_TIMEOUT, 16'd0);
                    write_reg(amcf_pkg::REG_BUSY_LINE_USED, 16'd1);
                end
            endcase
            target = (ph + 1) * (RAND_ITEMS / 4);
            while (queued_items < target) begin
                if ($urandom_range(0, 9) < 7)
                    play_story();
                else
                    noise_item();
                // In phase 0 the sender holds off mid-phase until all results are back.
                if (ph == 0 && queued_items >= target / 2 &&
                    queued_items < target / 2 + 12)
                    wait_idle();
            end
            wait_idle();
        end

        $display("covered %0d frames and %0d ticks (%0d start timeouts)",
                 n_frames, n_ticks, n_timeouts,
                 " over %0d register writes", n_settings - 1);
        $display("%0d results checked, %0d failures", checked, errors);
        if (errors == 0 && expected_out.size() == 0) begin
            $display("PASS audio_module_command_framer_unit");
        end else begin
            $display("FAIL audio_module_command_framer_unit");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/amcf_pkg.sv
rtl/core/amcf_front.sv
rtl/core/amcf_queue.sv
rtl/core/amcf_back.sv
rtl/core/audio_module_command_framer_unit.sv
verif/tb.sv
